// ----- rtl/lzd_pkg.sv -----
package lzd_pkg;

  localparam int BYTE_BITS  = 8;
  localparam int DIST_BITS  = 12;
  localparam int CNT_BITS   = 5;
  localparam int POS_BITS   = 3;
  localparam int MIN_MATCH  = 3;

  localparam logic [POS_BITS-1:0] POS_LAST = 3'd7;

  typedef enum logic [2:0] {
    ST_FLAG,
    ST_TOKEN,
    ST_SECOND,
    ST_PRIME,
    ST_COPY
  } lzd_state_t;

  typedef struct packed {
    logic cfg_load;
    logic ld_flag;
    logic ld_low;
    logic lit_emit;
    logic start_copy;
    logic copy_adv;
    logic next_tok;
  } lzd_cmd_t;

  typedef struct packed {
    logic flag_bit;
    logic pos_last;
    logic rem_zero;
    logic rem_one;
    logic cnt_one;
    logic out_free;
  } lzd_stat_t;

endpackage

// ----- rtl/lzss_byte_decompressor.sv -----
// LZSS byte decompressor, 4096-byte history.
// Input channel (in_valid/in_stall/in_byte) takes one compressed byte per
// transfer: flag bytes, literals and two-byte match tokens. Output channel
// (out_valid/out_stall/out_byte/out_last) gives one decompressed byte per
// transfer, out_last marking the byte that completes the programmed length.
// cfg_valid/cfg_ready/cfg_data writes the output length, which restarts the
// parser at a flag byte and keeps the history. The user is to write it only
// while the block is idle; the block itself does not enforce this.
// A literal is in the output register the cycle after its transfer. A match
// of len bytes (len = 3..18, clipped to the bytes still owed) primes the
// history read in ST_PRIME after its second byte, then copies one byte per
// cycle while the output is free, through the single read port of the
// history memory; input is stalled meanwhile. A stalled output holds its
// byte and freezes the copy; literals then stall the input as well.
// After reset the length is zero, so input bytes are taken and dropped
// until a length is written. No clearing pass is run on the history.
module lzss_byte_decompressor #(
  parameter int WINDOW_DEPTH = 4096,
  parameter int LENGTH_BITS  = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [7:0]             in_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [7:0]             out_byte,
  output logic                   out_last,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [LENGTH_BITS-1:0] cfg_data
);
  import lzd_pkg::*;

  lzd_cmd_t  cmd;
  lzd_stat_t stat;
  logic      cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  lzd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cfg_we   (cfg_we),
    .stat     (stat),
    .cmd      (cmd)
  );

  lzd_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .LENGTH_BITS  (LENGTH_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_byte),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

// ----- rtl/lzd_ctrl.sv -----
module lzd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cfg_we,
  input  lzd_pkg::lzd_stat_t stat,
  output lzd_pkg::lzd_cmd_t  cmd
);
  import lzd_pkg::*;

  lzd_state_t state_r, state_nxt;
  logic       in_acc;
  logic       take;

  assign in_acc = in_valid && !in_stall;
  // an accepted byte only counts while output is still owed
  assign take   = in_acc && !stat.rem_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FLAG;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    if (cfg_we) begin
      state_nxt = ST_FLAG;
    end else begin
      unique case (state_r)
        ST_FLAG: begin
          if (take) state_nxt = ST_TOKEN;
        end
        ST_TOKEN: begin
          if (take) begin
            if (stat.flag_bit) begin
              state_nxt = stat.pos_last ? ST_FLAG : ST_TOKEN;
            end else begin
              state_nxt = ST_SECOND;
            end
          end
        end
        ST_SECOND: begin
          if (take) state_nxt = ST_PRIME;
        end
        ST_PRIME: begin
          state_nxt = ST_COPY;
        end
        ST_COPY: begin
          if (stat.out_free && (stat.cnt_one || stat.rem_one)) begin
            state_nxt = stat.pos_last ? ST_FLAG : ST_TOKEN;
          end
        end
        default: state_nxt = ST_FLAG;
      endcase
    end
  end

  always_comb begin
    cmd          = '0;
    in_stall     = 1'b0;
    cmd.cfg_load = cfg_we;
    unique case (state_r)
      ST_FLAG: begin
        cmd.ld_flag = take;
      end
      ST_TOKEN: begin
        in_stall     = !stat.rem_zero && stat.flag_bit && !stat.out_free;
        cmd.lit_emit = take && stat.flag_bit;
        cmd.ld_low   = take && !stat.flag_bit;
        cmd.next_tok = take && stat.flag_bit;
      end
      ST_SECOND: begin
        cmd.start_copy = take;
      end
      ST_PRIME: begin
        in_stall = 1'b1;
      end
      ST_COPY: begin
        in_stall     = 1'b1;
        cmd.copy_adv = stat.out_free;
        cmd.next_tok = stat.out_free && (stat.cnt_one || stat.rem_one);
      end
      default: in_stall = 1'b1;
    endcase
  end

endmodule

// ----- rtl/lzd_dp.sv -----
module lzd_dp #(
  parameter int WINDOW_DEPTH = 4096,
  parameter int LENGTH_BITS  = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [7:0]              in_byte,
  input  logic [LENGTH_BITS-1:0]  cfg_data,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic [7:0]              out_byte,
  output logic                    out_last,
  input  lzd_pkg::lzd_cmd_t       cmd,
  output lzd_pkg::lzd_stat_t      stat
);
  import lzd_pkg::*;

  localparam int AW = $clog2(WINDOW_DEPTH);

  logic [BYTE_BITS-1:0]   mem [WINDOW_DEPTH];

  logic [BYTE_BITS-1:0]   flag_bits_r, flag_bits_nxt;
  logic [POS_BITS-1:0]    pos_r, pos_nxt;
  logic [BYTE_BITS-1:0]   low_r, low_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [AW-1:0]          wp_r, wp_nxt;
  logic [AW-1:0]          src_r, src_nxt;
  logic [CNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic                   ov_r, ov_nxt;
  logic [BYTE_BITS-1:0]   ob_r, ob_nxt;
  logic                   ol_r, ol_nxt;

  logic [BYTE_BITS-1:0]   rd_data_r;
  logic                   fwd_r;
  logic [BYTE_BITS-1:0]   fwd_data_r;
  logic [BYTE_BITS-1:0]   copy_byte;
  logic [AW-1:0]          rd_addr;
  logic                   we;
  logic [BYTE_BITS-1:0]   wr_data;
  logic [DIST_BITS-1:0]   dist_code;

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_last  = ol_r;

  assign copy_byte = fwd_r ? fwd_data_r : rd_data_r;
  assign we        = cmd.lit_emit || cmd.copy_adv;
  assign wr_data   = cmd.lit_emit ? in_byte : copy_byte;
  // next source address is read as the current one is emitted
  assign rd_addr   = cmd.copy_adv ? src_r + AW'(1) : src_r;
  assign dist_code = {in_byte, low_r[7:4]};

  assign stat.flag_bit = flag_bits_r[pos_r];
  assign stat.pos_last = (pos_r == POS_LAST);
  assign stat.rem_zero = (rem_r == '0);
  assign stat.rem_one  = (rem_r == LENGTH_BITS'(1));
  assign stat.cnt_one  = (cnt_r == CNT_BITS'(1));
  assign stat.out_free = !ov_r || !out_stall;

  always_ff @(posedge clk) begin
    if (we) mem[wp_r] <= wr_data;
    rd_data_r  <= mem[rd_addr];
    fwd_r      <= we && (wp_r == rd_addr);
    fwd_data_r <= wr_data;
  end

  always_comb begin
    flag_bits_nxt = flag_bits_r;
    pos_nxt       = pos_r;
    low_nxt       = low_r;
    rem_nxt       = rem_r;
    wp_nxt        = wp_r;
    src_nxt       = src_r;
    cnt_nxt       = cnt_r;
    ov_nxt        = ov_r && out_stall;
    ob_nxt        = ob_r;
    ol_nxt        = ol_r;

    if (cmd.cfg_load) begin
      rem_nxt       = cfg_data;
      flag_bits_nxt = '0;
      pos_nxt       = '0;
      low_nxt       = '0;
    end
    if (cmd.ld_flag) begin
      flag_bits_nxt = in_byte;
      pos_nxt       = '0;
    end
    if (cmd.ld_low) low_nxt = in_byte;
    if (cmd.start_copy) begin
      src_nxt = wp_r - AW'(dist_code) - AW'(1);
      cnt_nxt = CNT_BITS'(low_r[3:0]) + CNT_BITS'(MIN_MATCH);
    end
    if (we) begin
      wp_nxt  = wp_r + AW'(1);
      rem_nxt = rem_r - LENGTH_BITS'(1);
      ov_nxt  = 1'b1;
      ob_nxt  = wr_data;
      ol_nxt  = (rem_r == LENGTH_BITS'(1));
    end
    if (cmd.copy_adv) begin
      src_nxt = src_r + AW'(1);
      cnt_nxt = cnt_r - CNT_BITS'(1);
    end
    if (cmd.next_tok) pos_nxt = pos_r + POS_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_bits_r <= '0;
      pos_r       <= '0;
      low_r       <= '0;
      rem_r       <= '0;
      wp_r        <= '0;
      cnt_r       <= '0;
      ov_r        <= 1'b0;
    end else begin
      flag_bits_r <= flag_bits_nxt;
      pos_r       <= pos_nxt;
      low_r       <= low_nxt;
      rem_r       <= rem_nxt;
      wp_r        <= wp_nxt;
      cnt_r       <= cnt_nxt;
      ov_r        <= ov_nxt;
    end
    src_r <= src_nxt;
    ob_r  <= ob_nxt;
    ol_r  <= ol_nxt;
  end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import lzd_pkg::*;

  localparam int LEN_W        = 24;
  localparam int HIST_DEPTH   = 4096;
  localparam int ITEM_TARGET  = 300;
  // a match of 18 bytes plus the prime state and the output register
  localparam int SETTLE_CYCLES = 24;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 2000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } out_beat_t;

  class lz_expansion_sb;
    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] owed;
    lzd_state_t       phase;
    logic [7:0]       flags;
    logic [2:0]       slot;
    logic [7:0]       token_lo;
    logic [7:0]       window [HIST_DEPTH];
    logic [11:0]      wr_ptr;
    int unsigned      filled;
    out_beat_t        due_bytes [$];

    function new();
      length_reg = '0;
      owed = '0;
      phase = ST_FLAG;
      flags = '0;
      slot = '0;
      token_lo = '0;
      wr_ptr = '0;
      filled = 0;
      foreach (window[i]) window[i] = '0;
    endfunction

    function void set_length(logic [LEN_W-1:0] v);
      length_reg = v;
      owed = v;
      phase = ST_FLAG;
      flags = '0;
      slot = '0;
      token_lo = '0;
    endfunction

    function void produce(logic [7:0] b);
      window[wr_ptr] = b;
      wr_ptr = wr_ptr + 12'd1;
      owed = owed - 1'b1;
      due_bytes.push_back('{data: b, last: (owed == '0)});
      if (filled < HIST_DEPTH) filled++;
    endfunction

    function void advance_slot();
      slot = slot + 3'd1;
      phase = (slot == '0) ? ST_FLAG : ST_TOKEN;
    endfunction

    function void take_code_byte(logic [7:0] b);
      int unsigned run;
      logic [11:0] back;
      if (owed == '0) return;
      case (phase)
        ST_FLAG: begin
          flags = b;
          slot = '0;
          phase = ST_TOKEN;
        end
        ST_TOKEN: begin
          if (flags[slot]) begin
            produce(b);
            advance_slot();
          end else begin
            token_lo = b;
            phase = ST_SECOND;
          end
        end
        default: begin
          run = int'(token_lo[3:0]) + MIN_MATCH;
          back = {b, token_lo[7:4]};
          if (run > owed) run = owed;
          // source moves along with the write pointer, so overlaps repeat
          repeat (run) produce(window[wr_ptr - back - 12'd1]);
          advance_slot();
        end
      endcase
    endfunction

    function bit check_byte(logic [7:0] data, logic last, output string why);
      out_beat_t want;
      if (due_bytes.size() == 0) begin
        why = $sformatf("byte %02h with nothing expected", data);
        return 1'b0;
      end
      want = due_bytes.pop_front();
      why = "";
      if (data !== want.data) why = $sformatf("byte %02h, expected %02h", data, want.data);
      if (last !== want.last)
        why = {why, $sformatf(" last %b, expected %b", last, want.last)};
      return why == "";
    endfunction

    function int pending();
      return due_bytes.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n     = 1'b0;
  logic             in_valid  = 1'b0;
  logic             in_stall;
  logic [7:0]       in_byte   = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_byte;
  logic             out_last;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data  = '0;

  lz_expansion_sb board = new();
  int error_count = 0;
  int idle_cycles = 0;
  int long_hold_req = 0;
  int burst_left = 0;
  bit gaps_on = 1'b0;
  int items_sent = 0;

  lzss_byte_decompressor #(
    .WINDOW_DEPTH(HIST_DEPTH),
    .LENGTH_BITS (LEN_W)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .out_last (out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string why);
    error_count++;
    if (error_count <= 30) $display("%0t ns mismatch: %s", $time, why);
  endtask

  // results are checked before the input of the same edge is noted
  always @(posedge clk) begin
    string why;
    if (rst_n) begin
      if (out_valid && !out_stall)
        if (!board.check_byte(out_byte, out_last, why)) report_mismatch(why);
      if (cfg_valid && cfg_ready) board.set_length(cfg_data);
      if (in_valid && !in_stall) board.take_code_byte(in_byte);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (long_hold_req != 0) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 0;
      end else begin
        n = $urandom_range(4, 40);
        case ($urandom_range(0, 3))
          0: begin
            out_stall <= 1'b0;
            repeat (n) @(posedge clk);
          end
          1: begin
            out_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
          end
          default: begin
            repeat (n) begin
              out_stall <= ($urandom_range(0, 2) == 0);
              @(posedge clk);
            end
          end
        endcase
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic feed(input logic [7:0] b);
    int gap;
    send_byte(b);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = gaps_on ? $urandom_range(0, 12) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // a token byte that gives no result may still be in flight
  task automatic settle();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // well-formed stream for one block; matches only reach into written history
  task automatic run_block(input int unsigned len, input bit cut, input int match_pct,
                           input bit long_runs);
    int unsigned owed, fill, stop_at, sent, run, span;
    logic [11:0] dm;
    logic [3:0]  code;
    logic [7:0]  flag;
    logic [7:0]  grp [$];
    settle();
    write_length(len[LEN_W-1:0]);
    fill = board.filled;
    owed = len;
    sent = 0;
    stop_at = cut ? $urandom_range(1, 40) : 32'hffff_ffff;
    while (owed > 0 && sent < stop_at) begin
      grp.delete();
      flag = 8'($urandom);
      for (int i = 0; i < 8 && owed > 0; i++) begin
        if (fill == 0 || $urandom_range(0, 99) >= match_pct) begin
          flag[i] = 1'b1;
          grp.push_back(8'($urandom));
          owed--;
          if (fill < HIST_DEPTH) fill++;
        end else begin
          flag[i] = 1'b0;
          code = (long_runs || $urandom_range(0, 2) == 0) ? 4'd15 : 4'($urandom_range(0, 15));
          case ($urandom_range(0, 3))
            0: span = fill;
            1: span = $urandom_range(1, fill);
            default: span = $urandom_range(1, (fill < 20) ? fill : 20);
          endcase
          dm = 12'(span - 1);
          grp.push_back({dm[3:0], code});
          grp.push_back(dm[11:4]);
          run = int'(code) + MIN_MATCH;
          if (run > owed) run = owed;
          owed -= run;
          fill = (fill + run > HIST_DEPTH) ? HIST_DEPTH : fill + run;
        end
      end
      feed(flag);
      sent++;
      foreach (grp[k]) begin
        if (sent >= stop_at) break;
        feed(grp[k]);
        sent++;
      end
      if (!cut && $urandom_range(0, 9) == 0) drain();
    end
    items_sent += sent;
    // trailing bytes after a finished block are dropped
    if (!cut) repeat ($urandom_range(0, 2)) feed(8'($urandom));
  endtask

  initial begin
    int blk;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // length is zero after reset: bytes are dropped
    feed(8'h00);
    feed(8'hff);

    settle();
    write_length('0);
    feed(8'h5a);

    settle();
    write_length(24'd1);
    feed(8'hff);
    feed(8'h00);
    feed(8'h3c);

    // two literals, overlapping copy at distance 1, copy clipped to what is owed
    settle();
    write_length(24'd12);
    feed(8'hf3);
    feed(8'hff);
    feed(8'ha5);
    feed(8'h00);
    feed(8'h00);
    feed(8'h1f);
    feed(8'h00);

    // full flag group, then a fresh flag byte; block left unfinished
    settle();
    write_length(24'd30);
    feed(8'hff);
    feed(8'h80);
    feed(8'h7f);
    feed(8'h01);
    feed(8'hfe);
    feed(8'h55);
    feed(8'haa);
    feed(8'h0f);
    feed(8'hf0);
    feed(8'h00);
    feed(8'hf0);
    feed(8'h00);

    settle();
    write_length({LEN_W{1'b1}});
    feed(8'h01);
    feed(8'h99);

    blk = 0;
    gaps_on = 1'b1;
    while (items_sent < ITEM_TARGET) begin
      blk++;
      if (blk == 3) begin
        // receiver holds off while the sender keeps offering long copies
        gaps_on = 1'b0;
        long_hold_req = 1;
        run_block(1200, 1'b0, 90, 1'b1);
      end else begin
        case ($urandom_range(0, 9))
          0: run_block(0, 1'b0, 60, 1'b0);
          1, 2: run_block($urandom_range(1, 40), 1'b1, 60, 1'b0);
          3: run_block($urandom_range(200, 600), 1'b0, 75, 1'b0);
          default: run_block($urandom_range(1, 120), 1'b0, 60, 1'b0);
        endcase
      end
      gaps_on = ($urandom_range(0, 3) != 0);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && board.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
